// File: design/drca_pkg.sv
// Shared constants, command and status types for the delay congestion rate adapter.
`default_nettype none

package drca_pkg;

  localparam int WINDOW_DEPTH     = 10;
  localparam int TICKS_PER_SECOND = 128;

  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  localparam int IVL_MIN   = TICKS_PER_SECOND / 5;
  localparam int IVL_MAX   = TICKS_PER_SECOND * 10;
  localparam int IVL_START = TICKS_PER_SECOND * 2;
  localparam int IVL_W     = $clog2(IVL_MAX + 1);
  localparam int SMOOTH_SHIFT = 3;

  localparam longint unsigned RATE_NUM_L = longint'(TICKS_PER_SECOND) * 64'd5000000;
  localparam logic [31:0]     RATE_NUM   = RATE_NUM_L[31:0];
  localparam bit NUM_GUARD =
    ((longint'(TICKS_PER_SECOND) * 64'd5000) > (64'hFFFFFFFF / 64'd1000));

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_IS_ROOT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = 2'd2;

  localparam logic [15:0] SLOT_LEN_RESET  = 16'd10000;
  localparam logic [30:0] MAX_DELAY_RESET = 31'd2000000;
  localparam logic [30:0] BASE_MIN_RESET  = 31'h7FFFFFFF;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;

  typedef struct packed {
    logic load;
    logic mul;
    logic check;
    logic scan;
    logic price;
    logic div_start;
    logic div_step;
    logic ewma;
    logic out_load;
  } drca_cmd_t;

  typedef struct packed {
    logic is_root;
    logic sample_ok;
    logic price_zero;
    logic scan_last;
    logic div_last;
    logic out_free;
  } drca_status_t;

endpackage

`default_nettype wire

// File: design/delay_congestion_rate_adapter.sv
// Top level of the delay congestion rate adapter: controller plus datapath.
// From acceptance, the root role loads the word, scales the delay and checks it; a discarded sample
// goes straight to output, and a used one is written to the window, scanned and priced. The leaf role
// runs the 32-step serial divider and then smoothing, or only the smoothing when the price is 0.
// One word is in flight: the next is accepted from the cycle after the result is loaded; a result not
// taken holds the controller. Reset (rst_n low, synchronous) restores register defaults,
// empties the window and sets baseline and interval to start.
`default_nettype none

module delay_congestion_rate_adapter (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire  [drca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [drca_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // sent_stamp[15:0], arrival_stamp[31:16], price_word[63:32]
  input  wire  [drca_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // sample_accepted[0], delay_sample_us[32:1], price_us[63:33],
  // target_interval_ticks[74:64], send_interval_ticks[85:75], zero pad[87:86]
  output logic [drca_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  drca_pkg::drca_cmd_t    cmd;
  drca_pkg::drca_status_t status;

  drca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  drca_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire

// File: design/drca_ctrl.sv
// Sequencing state machine of the delay congestion rate adapter.
`default_nettype none

module drca_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire drca_pkg::drca_status_t status,
  output drca_pkg::drca_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_PRICE = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EWMA  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (status.is_root) begin
          cmd.mul   = 1'b1;
          state_nxt = ST_CHECK;
        end else if (status.price_zero) begin
          state_nxt = ST_EWMA;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_CHECK: begin
        if (status.sample_ok) begin
          cmd.check = 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_PRICE;
        end
      end
      ST_PRICE: begin
        cmd.price = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_EWMA;
        end
      end
      ST_EWMA: begin
        cmd.ewma  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Hold the finished word until the output register has room.
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/drca_dp.sv
// Datapath: configuration, delay window, price, serial divider and interval smoothing.
`default_nettype none

module drca_dp (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_wr_en,
  input  wire  [drca_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [drca_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire  [drca_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [drca_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire drca_pkg::drca_cmd_t              cmd,
  output drca_pkg::drca_status_t                status
);

  // Configuration
  logic        is_root_r;
  logic [15:0] slot_len_r;
  logic [30:0] max_delay_r;

  // Item registers
  logic [15:0]        sent_r;
  logic [15:0]        arr_r;
  logic [30:0]        pin_r;
  logic signed [31:0] delay_r;
  logic               acc_r;

  // Window and price state
  logic [30:0]                   win_r [drca_pkg::WINDOW_DEPTH];
  logic [drca_pkg::PTR_W-1:0]    ptr_r;
  logic                          filled_r;
  logic [30:0]                   base_min_r;
  logic [30:0]                   price_r;
  logic [30:0]                   mx_r;
  logic [drca_pkg::PTR_W-1:0]    idx_r;
  logic [drca_pkg::CNT_W-1:0]    vcnt_r;

  // Divider and interval
  logic [30:0]                   rem_r;
  logic [31:0]                   quo_r;
  logic [drca_pkg::DIV_CNT_W-1:0] divcnt_r;
  logic [drca_pkg::IVL_W-1:0]    ivl_r;
  logic [drca_pkg::IVL_W-1:0]    target_r;

  logic                          out_valid_r;
  logic [drca_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [15:0]                   diff;
  logic signed [32:0]            prod;
  logic [drca_pkg::PTR_W-1:0]    ptr_nxt;
  logic                          filled_nxt;
  logic [30:0]                   win_rd;
  logic [31:0]                   trial;
  logic                          trial_ge;
  logic [drca_pkg::IVL_W-1:0]    tgt_clamped;
  logic [drca_pkg::IVL_W-1:0]    ivl_nxt;

  assign diff = arr_r - sent_r;
  assign prod = $signed(diff) * $signed({1'b0, slot_len_r});

  assign ptr_nxt = (ptr_r == drca_pkg::PTR_W'(drca_pkg::WINDOW_DEPTH - 1)) ?
                   '0 : ptr_r + 1'b1;
  assign filled_nxt = filled_r || (ptr_r == drca_pkg::PTR_W'(drca_pkg::WINDOW_DEPTH - 1));

  assign win_rd = win_r[idx_r];

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  assign trial    = {rem_r, quo_r[31]};
  assign trial_ge = (trial >= {1'b0, pin_r});

  always_comb begin
    if ((pin_r == '0) || drca_pkg::NUM_GUARD) begin
      tgt_clamped = drca_pkg::IVL_W'(drca_pkg::IVL_MAX);
    end else if (quo_r < 32'(drca_pkg::IVL_MIN)) begin
      tgt_clamped = drca_pkg::IVL_W'(drca_pkg::IVL_MIN);
    end else if (quo_r > 32'(drca_pkg::IVL_MAX)) begin
      tgt_clamped = drca_pkg::IVL_W'(drca_pkg::IVL_MAX);
    end else begin
      tgt_clamped = quo_r[drca_pkg::IVL_W-1:0];
    end
  end

  assign ivl_nxt = ivl_r - (ivl_r >> drca_pkg::SMOOTH_SHIFT)
                 + (tgt_clamped >> drca_pkg::SMOOTH_SHIFT);

  assign status.is_root    = is_root_r;
  assign status.sample_ok  = !delay_r[31] && (delay_r != '0) && (delay_r[30:0] <= max_delay_r);
  assign status.price_zero = (pin_r == '0);
  assign status.scan_last  = (drca_pkg::CNT_W'(idx_r) == vcnt_r - drca_pkg::CNT_W'(1));
  assign status.div_last   = (divcnt_r == drca_pkg::DIV_CNT_W'(drca_pkg::DIV_STEPS - 1));
  assign status.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // State that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_root_r   <= 1'b0;
      slot_len_r  <= drca_pkg::SLOT_LEN_RESET;
      max_delay_r <= drca_pkg::MAX_DELAY_RESET;
      ptr_r       <= '0;
      filled_r    <= 1'b0;
      base_min_r  <= drca_pkg::BASE_MIN_RESET;
      price_r     <= '0;
      ivl_r       <= drca_pkg::IVL_W'(drca_pkg::IVL_START);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          drca_pkg::REG_IS_ROOT:   is_root_r   <= cfg_wdata[0];
          drca_pkg::REG_SLOT_LEN:  slot_len_r  <= cfg_wdata[15:0];
          drca_pkg::REG_MAX_DELAY: max_delay_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.check) begin
        ptr_r    <= ptr_nxt;
        filled_r <= filled_nxt;
        if (delay_r[30:0] < base_min_r) begin
          base_min_r <= delay_r[30:0];
        end
      end
      if (cmd.price) begin
        price_r <= (mx_r >= base_min_r) ? (mx_r - base_min_r) : '0;
      end
      if (cmd.ewma) begin
        price_r <= pin_r;
        ivl_r   <= ivl_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sent_r   <= in_tdata[15:0];
      arr_r    <= in_tdata[31:16];
      // A negative received price counts as zero.
      pin_r    <= in_tdata[63] ? '0 : in_tdata[62:32];
      delay_r  <= '0;
      acc_r    <= 1'b0;
      target_r <= '0;
    end
    if (cmd.mul) begin
      delay_r <= prod[31:0];
    end
    if (cmd.check) begin
      win_r[ptr_r] <= delay_r[30:0];
      acc_r        <= 1'b1;
      mx_r         <= '0;
      idx_r        <= '0;
      vcnt_r       <= filled_nxt ? drca_pkg::CNT_W'(drca_pkg::WINDOW_DEPTH)
                                 : drca_pkg::CNT_W'(ptr_nxt);
    end
    if (cmd.scan) begin
      if (win_rd > mx_r) begin
        mx_r <= win_rd;
      end
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.div_start) begin
      rem_r    <= '0;
      quo_r    <= drca_pkg::RATE_NUM;
      divcnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r    <= trial_ge ? 31'(trial - {1'b0, pin_r}) : trial[30:0];
      quo_r    <= {quo_r[30:0], trial_ge};
      divcnt_r <= divcnt_r + 1'b1;
    end
    if (cmd.ewma) begin
      target_r <= tgt_clamped;
    end
    if (cmd.out_load) begin
      out_data_r <= {2'b00, 11'(ivl_r), 11'(target_r), price_r, delay_r, acc_r};
    end
  end

endmodule

`default_nettype wire

// File: design/drca_chk.sv
// Port-level checker for the delay congestion rate adapter, bound to the top level.
`default_nettype none

module drca_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [drca_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // Nothing is offered straight after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid after reset");

  // One word at a time: the block is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  // An accepted delay sample comes from the root path, which reports no target.
  a_root_no_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[74:64] == 11'd0)
    else $error("target reported with an accepted delay sample");

  a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[85:75] <= 11'(drca_pkg::IVL_MAX)) && (out_tdata[85:75] != 11'd0))
    else $error("send interval out of range");

endmodule

bind delay_congestion_rate_adapter drca_chk u_drca_chk (.*);

`default_nettype wire
